// ===== rtl/i2c_bit_level_master_macros.svh =====
// Assertion macros shared by the two-wire bus master.
`ifndef I2C_BIT_LEVEL_MASTER_MACROS_SVH
`define I2C_BIT_LEVEL_MASTER_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define I2CM_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("i2cm same-cycle check failed");

// The consequent holds in the cycle after the antecedent.
`define I2CM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("i2cm next-cycle check failed");

`endif

// ===== rtl/i2cm_pkg.sv =====
// Shared types and constants of the two-wire bus master.
`timescale 1ns / 1ps

package i2cm_pkg;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [2:0] KIND_TICK  = 3'd0;
    localparam logic [2:0] KIND_START = 3'd1;
    localparam logic [2:0] KIND_STOP  = 3'd2;
    localparam logic [2:0] KIND_WRITE = 3'd3;
    localparam logic [2:0] KIND_READ  = 3'd4;
    localparam logic [2:0] KIND_ACK   = 3'd5;
    localparam logic [2:0] KIND_WAIT  = 3'd6;

    localparam logic [1:0] CFG_SHORT_HOLD = 2'd0;
    localparam logic [1:0] CFG_POLL_LIMIT = 2'd1;

    localparam logic [15:0] SHORT_HOLD_RESET = 16'd2;
    localparam logic [7:0]  POLL_LIMIT_RESET = 8'd250;
    localparam logic [3:0]  BITS_PER_BYTE    = 4'd8;

    typedef struct packed {
        logic       is_tick;
        logic       is_cmd;
        logic [2:0] kind;
        logic [7:0] write_byte;
        logic       nack_bit;
        logic       sda_level;
    } item_t;

    typedef struct packed {
        logic       scl_level;
        logic       sda_drive;
        logic       sda_output_enable;
        logic       busy_res;
        logic       done_res;
        logic       accepted;
        logic [7:0] read_byte;
        logic       ack_failed;
    } res_t;

endpackage

// ===== rtl/i2cm_fifo.sv =====
// Small register-based queue used between the front, the sequencer and the result port.
`timescale 1ns / 1ps

module i2cm_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = i2cm_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  logic [WIDTH-1:0] din,
    input  logic             pop,
    output logic             empty,
    output logic [WIDTH-1:0] dout
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/i2cm_front.sv =====
// Front end: classifies each incoming item as a tick, a command or a code without meaning.
`timescale 1ns / 1ps

module i2cm_front (
    input  logic             [2:0] kind,
    input  logic             [7:0] write_byte,
    input  logic                   nack_bit,
    input  logic                   sda_level,
    output i2cm_pkg::item_t        item
);

    always_comb
    begin
        item.is_tick    = (kind == i2cm_pkg::KIND_TICK);
        item.is_cmd     = (kind == i2cm_pkg::KIND_START) || (kind == i2cm_pkg::KIND_STOP)
                       || (kind == i2cm_pkg::KIND_WRITE) || (kind == i2cm_pkg::KIND_READ)
                       || (kind == i2cm_pkg::KIND_ACK)   || (kind == i2cm_pkg::KIND_WAIT);
        item.kind       = kind;
        item.write_byte = write_byte;
        item.nack_bit   = nack_bit;
        item.sda_level  = sda_level;
    end

endmodule

// ===== rtl/i2cm_seq.sv =====
// Back end: bus pin sequencer, hold and poll counters, and configuration registers.
`timescale 1ns / 1ps

module i2cm_seq (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    input  logic             [1:0] cfg_index,
    input  logic            [15:0] cfg_data,
    input  i2cm_pkg::item_t        item,
    input  logic                   item_empty,
    output logic                   item_pop,
    output i2cm_pkg::res_t         res,
    input  logic                   res_full,
    output logic                   res_push
);

    logic [15:0] short_hold_reg;
    logic [7:0]  poll_limit_reg;

    logic [2:0]  active_reg,  active_next;
    logic [1:0]  phase_reg,   phase_next;
    logic [3:0]  bits_reg,    bits_next;
    logic [7:0]  shift_reg,   shift_next;
    logic [16:0] hold_reg,    hold_next;
    logic [7:0]  poll_reg,    poll_next;
    logic [7:0]  rdata_reg,   rdata_next;
    logic        scl_reg,     scl_next;
    logic        sda_reg,     sda_next;
    logic        oe_reg,      oe_next;
    logic        ack_reg,     ack_next;

    logic        go;
    logic        done;
    logic        acc;
    logic [15:0] short_hold;
    logic [16:0] short_hold_x;
    logic [16:0] long_hold;
    logic [3:0]  bits_inc;

    assign go           = !item_empty && !res_full;
    assign item_pop     = go;
    assign res_push     = go;
    assign short_hold   = (short_hold_reg == '0) ? 16'd1 : short_hold_reg;
    assign short_hold_x = {1'b0, short_hold};
    assign long_hold    = {short_hold, 1'b0};
    assign bits_inc     = bits_reg + 4'd1;

    always_comb
    begin
        active_next = active_reg;
        phase_next  = phase_reg;
        bits_next   = bits_reg;
        shift_next  = shift_reg;
        hold_next   = hold_reg;
        poll_next   = poll_reg;
        rdata_next  = rdata_reg;
        scl_next    = scl_reg;
        sda_next    = sda_reg;
        oe_next     = oe_reg;
        ack_next    = ack_reg;
        done        = 1'b0;
        acc         = 1'b0;

        if (go && item.is_tick && active_reg != i2cm_pkg::KIND_TICK)
        begin
            if (active_reg == i2cm_pkg::KIND_WAIT)
            begin
                if (!item.sda_level)
                begin
                    scl_next    = 1'b0;
                    ack_next    = 1'b0;
                    active_next = i2cm_pkg::KIND_TICK;
                    phase_next  = 2'd0;
                    done        = 1'b1;
                end
                else if (poll_reg >= poll_limit_reg)
                begin
                    ack_next    = 1'b1;
                    active_next = i2cm_pkg::KIND_TICK;
                    phase_next  = 2'd0;
                    done        = 1'b1;
                end
                else
                begin
                    poll_next = poll_reg + 8'd1;
                end
            end
            else if (hold_reg > 17'd1)
            begin
                hold_next = hold_reg - 17'd1;
            end
            else
            begin
                hold_next = '0;
                unique case (active_reg)
                    i2cm_pkg::KIND_START:
                    begin
                        if (phase_reg == 2'd0)
                        begin
                            sda_next   = 1'b0;
                            hold_next  = long_hold;
                            phase_next = 2'd1;
                        end
                        else
                        begin
                            scl_next = 1'b0;
                            done     = 1'b1;
                        end
                    end
                    i2cm_pkg::KIND_STOP:
                    begin
                        if (phase_reg == 2'd0)
                        begin
                            scl_next   = 1'b1;
                            hold_next  = long_hold;
                            phase_next = 2'd1;
                        end
                        else if (phase_reg == 2'd1)
                        begin
                            sda_next   = 1'b1;
                            hold_next  = long_hold;
                            phase_next = 2'd2;
                        end
                        else
                        begin
                            done = 1'b1;
                        end
                    end
                    i2cm_pkg::KIND_WRITE:
                    begin
                        if (phase_reg == 2'd0)
                        begin
                            scl_next   = 1'b1;
                            hold_next  = short_hold_x;
                            phase_next = 2'd1;
                        end
                        else if (phase_reg == 2'd1)
                        begin
                            scl_next   = 1'b0;
                            hold_next  = short_hold_x;
                            phase_next = 2'd2;
                        end
                        else
                        begin
                            bits_next = bits_inc;
                            if (bits_inc >= i2cm_pkg::BITS_PER_BYTE)
                            begin
                                done = 1'b1;
                            end
                            else
                            begin
                                sda_next   = shift_reg[7];
                                shift_next = {shift_reg[6:0], 1'b0};
                                hold_next  = short_hold_x;
                                phase_next = 2'd0;
                            end
                        end
                    end
                    i2cm_pkg::KIND_READ:
                    begin
                        if (phase_reg == 2'd0)
                        begin
                            scl_next   = 1'b1;
                            shift_next = {shift_reg[6:0], item.sda_level};
                            hold_next  = short_hold_x;
                            phase_next = 2'd1;
                        end
                        else
                        begin
                            bits_next = bits_inc;
                            scl_next  = 1'b0;
                            if (bits_inc >= i2cm_pkg::BITS_PER_BYTE)
                            begin
                                rdata_next = shift_reg;
                                done       = 1'b1;
                            end
                            else
                            begin
                                hold_next  = short_hold_x;
                                phase_next = 2'd0;
                            end
                        end
                    end
                    default:
                    begin
                        if (phase_reg == 2'd0)
                        begin
                            scl_next   = 1'b1;
                            hold_next  = short_hold_x;
                            phase_next = 2'd1;
                        end
                        else
                        begin
                            scl_next = 1'b0;
                            done     = 1'b1;
                        end
                    end
                endcase
                if (done)
                begin
                    active_next = i2cm_pkg::KIND_TICK;
                    phase_next  = 2'd0;
                end
            end
        end
        else if (go && item.is_cmd && active_reg == i2cm_pkg::KIND_TICK)
        begin
            acc         = 1'b1;
            active_next = item.kind;
            phase_next  = 2'd0;
            bits_next   = '0;
            unique case (item.kind)
                i2cm_pkg::KIND_START:
                begin
                    oe_next   = 1'b1;
                    sda_next  = 1'b1;
                    scl_next  = 1'b1;
                    hold_next = long_hold;
                end
                i2cm_pkg::KIND_STOP:
                begin
                    oe_next   = 1'b1;
                    sda_next  = 1'b0;
                    scl_next  = 1'b0;
                    hold_next = long_hold;
                end
                i2cm_pkg::KIND_WRITE:
                begin
                    oe_next    = 1'b1;
                    scl_next   = 1'b0;
                    sda_next   = item.write_byte[7];
                    shift_next = {item.write_byte[6:0], 1'b0};
                    hold_next  = short_hold_x;
                end
                i2cm_pkg::KIND_READ:
                begin
                    oe_next   = 1'b0;
                    sda_next  = 1'b1;
                    scl_next  = 1'b0;
                    hold_next = short_hold_x;
                end
                i2cm_pkg::KIND_ACK:
                begin
                    oe_next   = 1'b1;
                    scl_next  = 1'b0;
                    sda_next  = item.nack_bit;
                    hold_next = short_hold_x;
                end
                default:
                begin
                    oe_next   = 1'b0;
                    sda_next  = 1'b1;
                    scl_next  = 1'b1;
                    poll_next = '0;
                    ack_next  = 1'b0;
                    hold_next = '0;
                end
            endcase
        end
    end

    always_comb
    begin
        res.scl_level         = scl_next;
        res.sda_drive         = oe_next ? sda_next : 1'b1;
        res.sda_output_enable = oe_next;
        res.busy_res          = (active_next != i2cm_pkg::KIND_TICK);
        res.done_res          = done;
        res.accepted          = acc;
        res.read_byte         = rdata_next;
        res.ack_failed        = ack_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            short_hold_reg <= i2cm_pkg::SHORT_HOLD_RESET;
            poll_limit_reg <= i2cm_pkg::POLL_LIMIT_RESET;
            active_reg     <= i2cm_pkg::KIND_TICK;
            phase_reg      <= '0;
            bits_reg       <= '0;
            shift_reg      <= '0;
            hold_reg       <= '0;
            poll_reg       <= '0;
            rdata_reg      <= '0;
            scl_reg        <= 1'b1;
            sda_reg        <= 1'b1;
            oe_reg         <= 1'b0;
            ack_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_index == i2cm_pkg::CFG_SHORT_HOLD)
            begin
                short_hold_reg <= cfg_data;
            end
            if (cfg_valid && cfg_index == i2cm_pkg::CFG_POLL_LIMIT)
            begin
                poll_limit_reg <= cfg_data[7:0];
            end
            active_reg <= active_next;
            phase_reg  <= phase_next;
            bits_reg   <= bits_next;
            shift_reg  <= shift_next;
            hold_reg   <= hold_next;
            poll_reg   <= poll_next;
            rdata_reg  <= rdata_next;
            scl_reg    <= scl_next;
            sda_reg    <= sda_next;
            oe_reg     <= oe_next;
            ack_reg    <= ack_next;
        end
    end

endmodule

// ===== rtl/i2c_bit_level_master.sv =====
// Top level of the two-wire bus master: front end, item queue, sequencer and result queue.
//
//   Channel   Handshake            Payload
//   input     push / full          kind, write_byte, nack_bit, sda_level
//   result    empty / pop          scl_level .. ack_failed
//   config    cfg_valid/cfg_ready  cfg_index, cfg_data
//
// Every item yields one result; the sequencer handles one item per cycle while the
// result queue has room; each item passes both queues before its result shows.
// The item queue and the result queue each hold QUEUE_DEPTH entries; while the result
// queue is full the sequencer waits, and the item queue then fills and raises full.
// Reset is asynchronous; it empties the queues and resets the sequencer and registers.
`timescale 1ns / 1ps

`include "i2c_bit_level_master_macros.svh"

module i2c_bit_level_master #(
    parameter int QUEUE_DEPTH = i2cm_pkg::QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [2:0]  kind,
    input  logic [7:0]  write_byte,
    input  logic        nack_bit,
    input  logic        sda_level,
    output logic        empty,
    input  logic        pop,
    output logic        scl_level,
    output logic        sda_drive,
    output logic        sda_output_enable,
    output logic        busy_res,
    output logic        done_res,
    output logic        accepted,
    output logic [7:0]  read_byte,
    output logic        ack_failed,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    i2cm_pkg::item_t in_item;
    i2cm_pkg::item_t q_item;
    i2cm_pkg::res_t  seq_res;
    i2cm_pkg::res_t  out_res;
    logic            q_empty;
    logic            q_pop;
    logic            res_full;
    logic            res_push;

    assign cfg_ready = 1'b1;

    i2cm_front u_front (
        .kind       (kind),
        .write_byte (write_byte),
        .nack_bit   (nack_bit),
        .sda_level  (sda_level),
        .item       (in_item)
    );

    i2cm_fifo #(
        .WIDTH ($bits(i2cm_pkg::item_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_item_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (full),
        .din   (in_item),
        .pop   (q_pop),
        .empty (q_empty),
        .dout  (q_item)
    );

    i2cm_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .item       (q_item),
        .item_empty (q_empty),
        .item_pop   (q_pop),
        .res        (seq_res),
        .res_full   (res_full),
        .res_push   (res_push)
    );

    i2cm_fifo #(
        .WIDTH ($bits(i2cm_pkg::res_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .full  (res_full),
        .din   (seq_res),
        .pop   (pop),
        .empty (empty),
        .dout  (out_res)
    );

    assign scl_level         = out_res.scl_level;
    assign sda_drive         = out_res.sda_drive;
    assign sda_output_enable = out_res.sda_output_enable;
    assign busy_res          = out_res.busy_res;
    assign done_res          = out_res.done_res;
    assign accepted          = out_res.accepted;
    assign read_byte         = out_res.read_byte;
    assign ack_failed        = out_res.ack_failed;

    `I2CM_ASSERT_SAME(a_done_not_busy, res_push && seq_res.done_res, !seq_res.busy_res)
    `I2CM_ASSERT_SAME(a_accept_busy, res_push && seq_res.accepted, seq_res.busy_res)
    `I2CM_ASSERT_NEXT(a_push_shows, res_push, !empty)
    `I2CM_ASSERT_SAME(a_pop_with_room, q_pop, !res_full && !q_empty)

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the two-wire bus master: directed and random requests.
`timescale 1ns / 1ps

localparam logic [2:0] CMD_IDLE    = 3'd0;
localparam logic [2:0] KIND_UNUSED = 3'd7;

class bus_master_scoreboard;
    i2cm_pkg::res_t pending_states[$];
    int          errors;
    logic [15:0] short_hold_cfg;
    logic [7:0]  poll_limit_cfg;
    logic [2:0]  command;
    logic [2:0]  phase;
    logic [3:0]  bit_count;
    logic [7:0]  shift_reg;
    logic [16:0] hold_left;
    logic [7:0]  polls;
    logic [7:0]  read_data;
    logic        scl;
    logic        sda;
    logic        oe;
    logic        ack_fail;

    function void clear_state();
        pending_states.delete();
        errors         = 0;
        short_hold_cfg = i2cm_pkg::SHORT_HOLD_RESET;
        poll_limit_cfg = i2cm_pkg::POLL_LIMIT_RESET;
        command        = CMD_IDLE;
        phase          = 3'd0;
        bit_count      = 4'd0;
        shift_reg      = 8'd0;
        hold_left      = 17'd0;
        polls          = 8'd0;
        read_data      = 8'd0;
        scl            = 1'b1;
        sda            = 1'b1;
        oe             = 1'b0;
        ack_fail       = 1'b0;
    endfunction

    function void set_register(logic [1:0] index, logic [15:0] value);
        if (index == i2cm_pkg::CFG_SHORT_HOLD)
            short_hold_cfg = value;
        else if (index == i2cm_pkg::CFG_POLL_LIMIT)
            poll_limit_cfg = value[7:0];
    endfunction

    function bit busy();
        return command != CMD_IDLE;
    endfunction

    function int pending();
        return pending_states.size();
    endfunction

    function logic [16:0] short_hold_len();
        return (short_hold_cfg == 16'd0) ? 17'd1 : {1'b0, short_hold_cfg};
    endfunction

    function logic [16:0] long_hold_len();
        return short_hold_len() << 1;
    endfunction

    function void shift_out_bit();
        sda       = shift_reg[7];
        shift_reg = shift_reg << 1;
    endfunction

    function void launch(logic [2:0] kind, logic [7:0] data, logic nack);
        command   = kind;
        phase     = 3'd0;
        bit_count = 4'd0;
        case (kind)
            i2cm_pkg::KIND_START:
            begin
                oe = 1'b1; sda = 1'b1; scl = 1'b1;
                hold_left = long_hold_len();
            end
            i2cm_pkg::KIND_STOP:
            begin
                oe = 1'b1; sda = 1'b0; scl = 1'b0;
                hold_left = long_hold_len();
            end
            i2cm_pkg::KIND_WRITE:
            begin
                oe = 1'b1; scl = 1'b0;
                shift_reg = data;
                shift_out_bit();
                hold_left = short_hold_len();
            end
            i2cm_pkg::KIND_READ:
            begin
                oe = 1'b0; sda = 1'b1; scl = 1'b0;
                hold_left = short_hold_len();
            end
            i2cm_pkg::KIND_ACK:
            begin
                oe = 1'b1; scl = 1'b0; sda = nack;
                hold_left = short_hold_len();
            end
            default:
            begin
                oe = 1'b0; sda = 1'b1; scl = 1'b1;
                polls     = 8'd0;
                ack_fail  = 1'b0;
                hold_left = 17'd0;
            end
        endcase
    endfunction

    // Returns 1 when the running command completes on this tick.
    function logic step_tick(logic sda_in);
        logic done;
        done = 1'b0;
        if (command == i2cm_pkg::KIND_WAIT) begin
            if (!sda_in) begin
                scl      = 1'b0;
                ack_fail = 1'b0;
                done     = 1'b1;
            end
            else if (polls >= poll_limit_cfg) begin
                ack_fail = 1'b1;
                done     = 1'b1;
            end
            else begin
                polls = polls + 8'd1;
            end
        end
        else if (hold_left > 17'd1) begin
            hold_left = hold_left - 17'd1;
        end
        else begin
            hold_left = 17'd0;
            case (command)
                i2cm_pkg::KIND_START:
                begin
                    if (phase == 3'd0) begin
                        sda = 1'b0; hold_left = long_hold_len(); phase = 3'd1;
                    end
                    else begin
                        scl = 1'b0; done = 1'b1;
                    end
                end
                i2cm_pkg::KIND_STOP:
                begin
                    if (phase == 3'd0) begin
                        scl = 1'b1; hold_left = long_hold_len(); phase = 3'd1;
                    end
                    else if (phase == 3'd1) begin
                        sda = 1'b1; hold_left = long_hold_len(); phase = 3'd2;
                    end
                    else begin
                        done = 1'b1;
                    end
                end
                i2cm_pkg::KIND_WRITE:
                begin
                    if (phase == 3'd0) begin
                        scl = 1'b1; hold_left = short_hold_len(); phase = 3'd1;
                    end
                    else if (phase == 3'd1) begin
                        scl = 1'b0; hold_left = short_hold_len(); phase = 3'd2;
                    end
                    else begin
                        bit_count = bit_count + 4'd1;
                        if (bit_count >= i2cm_pkg::BITS_PER_BYTE) begin
                            done = 1'b1;
                        end
                        else begin
                            shift_out_bit();
                            hold_left = short_hold_len();
                            phase     = 3'd0;
                        end
                    end
                end
                i2cm_pkg::KIND_READ:
                begin
                    if (phase == 3'd0) begin
                        scl       = 1'b1;
                        shift_reg = {shift_reg[6:0], sda_in};
                        hold_left = short_hold_len();
                        phase     = 3'd1;
                    end
                    else begin
                        bit_count = bit_count + 4'd1;
                        scl       = 1'b0;
                        if (bit_count >= i2cm_pkg::BITS_PER_BYTE) begin
                            read_data = shift_reg;
                            done      = 1'b1;
                        end
                        else begin
                            hold_left = short_hold_len();
                            phase     = 3'd0;
                        end
                    end
                end
                default:
                begin
                    if (phase == 3'd0) begin
                        scl = 1'b1; hold_left = short_hold_len(); phase = 3'd1;
                    end
                    else begin
                        scl = 1'b0; done = 1'b1;
                    end
                end
            endcase
        end
        if (done) begin
            command = CMD_IDLE;
            phase   = 3'd0;
        end
        return done;
    endfunction

    function void note_request(logic [2:0] kind, logic [7:0] data, logic nack, logic sda_in);
        i2cm_pkg::res_t state;
        logic done;
        logic taken;
        done  = 1'b0;
        taken = 1'b0;
        if (kind == i2cm_pkg::KIND_TICK) begin
            if (busy())
                done = step_tick(sda_in);
        end
        else if (kind != KIND_UNUSED && !busy()) begin
            taken = 1'b1;
            launch(kind, data, nack);
        end
        state.scl_level         = scl;
        state.sda_drive         = oe ? sda : 1'b1;
        state.sda_output_enable = oe;
        state.busy_res          = busy();
        state.done_res          = done;
        state.accepted          = taken;
        state.read_byte         = read_data;
        state.ack_failed        = ack_fail;
        pending_states.push_back(state);
    endfunction

    function void flag(string msg);
        errors++;
        if (errors <= 10)
            $display("%0t: %s", $realtime, msg);
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] seen);
        if (seen !== want)
            flag($sformatf("%s mismatch: expected %h, got %h", name, want, seen));
    endfunction

    function void check_result(i2cm_pkg::res_t seen);
        i2cm_pkg::res_t want;
        if (pending_states.size() == 0) begin
            flag("result arrived with no request outstanding");
        end
        else begin
            want = pending_states.pop_front();
            compare_field("scl_level", 8'(want.scl_level), 8'(seen.scl_level));
            compare_field("sda_drive", 8'(want.sda_drive), 8'(seen.sda_drive));
            compare_field("sda_output_enable", 8'(want.sda_output_enable),
                          8'(seen.sda_output_enable));
            compare_field("busy_res", 8'(want.busy_res), 8'(seen.busy_res));
            compare_field("done_res", 8'(want.done_res), 8'(seen.done_res));
            compare_field("accepted", 8'(want.accepted), 8'(seen.accepted));
            compare_field("read_byte", want.read_byte, seen.read_byte);
            compare_field("ack_failed", 8'(want.ack_failed), 8'(seen.ack_failed));
        end
    endfunction
endclass

module testbench;

    localparam int WATCHDOG_LIMIT = 10000;
    localparam int SDA_LOW        = 0;
    localparam int SDA_HIGH       = 1;
    localparam int SDA_RANDOM     = 2;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [2:0]  kind = i2cm_pkg::KIND_TICK;
    logic [7:0]  write_byte = 8'd0;
    logic        nack_bit = 1'b0;
    logic        sda_level = 1'b0;
    logic        empty;
    logic        pop = 1'b0;
    logic        scl_level;
    logic        sda_drive;
    logic        sda_output_enable;
    logic        busy_res;
    logic        done_res;
    logic        accepted;
    logic [7:0]  read_byte;
    logic        ack_failed;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = i2cm_pkg::CFG_SHORT_HOLD;
    logic [15:0] cfg_data = 16'd0;

    bus_master_scoreboard sb;
    int unsigned tx_idle_pct = 0;
    int unsigned rx_stall_pct = 0;
    int          rx_hold_left = 0;
    int          quiet_cycles = 0;
    bit          wait_all_high = 1'b0;

    i2c_bit_level_master i_dut (.*);

    always #5 clk = ~clk;

    always @(negedge clk) begin
        if (!rst_n) begin
            pop <= 1'b0;
        end
        else if (rx_hold_left > 0) begin
            pop <= 1'b0;
            rx_hold_left = rx_hold_left - 1;
        end
        else begin
            pop <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge clk) begin : monitor
        i2cm_pkg::res_t seen;
        if (rst_n) begin
            if (pop && !empty) begin
                seen.scl_level         = scl_level;
                seen.sda_drive         = sda_drive;
                seen.sda_output_enable = sda_output_enable;
                seen.busy_res          = busy_res;
                seen.done_res          = done_res;
                seen.accepted          = accepted;
                seen.read_byte         = read_byte;
                seen.ack_failed        = ack_failed;
                sb.check_result(seen);
            end
            if ((pop && !empty) || (push && !full))
                quiet_cycles = 0;
            else
                quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    task automatic send_item(input logic [2:0] k, input logic [7:0] b,
                             input logic n, input logic s);
        @(negedge clk);
        while ($urandom_range(99) < tx_idle_pct) begin
            push <= 1'b0;
            @(negedge clk);
        end
        push       <= 1'b1;
        kind       <= k;
        write_byte <= b;
        nack_bit   <= n;
        sda_level  <= s;
        @(posedge clk);
        while (full)
            @(posedge clk);
        sb.note_request(k, b, n, s);
    endtask

    task automatic drive_until_idle(input int sda_mode);
        logic s;
        while (sb.busy()) begin
            if (sda_mode == SDA_RANDOM)
                s = 1'($urandom);
            else
                s = (sda_mode == SDA_HIGH);
            send_item(i2cm_pkg::KIND_TICK, 8'($urandom), 1'($urandom), s);
        end
    endtask

    task automatic settle();
        drive_until_idle(SDA_LOW);
        @(negedge clk);
        push <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_register(input logic [1:0] index, input logic [15:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.set_register(index, value);
    endtask

    task automatic configure(input logic [15:0] short_hold, input logic [7:0] poll_limit);
        settle();
        write_register(i2cm_pkg::CFG_SHORT_HOLD, short_hold);
        write_register(i2cm_pkg::CFG_POLL_LIMIT, {8'd0, poll_limit});
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_random(input int count);
        logic [2:0] k;
        logic [7:0] b;
        logic       n;
        logic       s;
        int         r;
        repeat (count) begin
            r = $urandom_range(99);
            if (!sb.busy()) begin
                if (r < 8)
                    k = i2cm_pkg::KIND_TICK;
                else if (r < 12)
                    k = KIND_UNUSED;
                else
                    k = 3'($urandom_range(1, 6));
                if (k == i2cm_pkg::KIND_WAIT)
                    wait_all_high = ($urandom_range(2) == 0);
            end
            else begin
                if (r < 90)
                    k = i2cm_pkg::KIND_TICK;
                else if (r < 96)
                    k = 3'($urandom_range(1, 6));
                else
                    k = KIND_UNUSED;
            end
            b = 8'($urandom);
            n = 1'($urandom);
            if (sb.command == i2cm_pkg::KIND_WAIT && wait_all_high)
                s = 1'b1;
            else
                s = 1'($urandom);
            send_item(k, b, n, s);
        end
    endtask

    initial begin
        sb = new;
        sb.clear_state();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_item(i2cm_pkg::KIND_TICK, 8'h00, 1'b0, 1'b1);
        send_item(KIND_UNUSED, 8'hFF, 1'b1, 1'b0);
        configure(16'd1, 8'd1);
        send_item(i2cm_pkg::KIND_START, 8'h00, 1'b0, 1'b0);
        send_item(i2cm_pkg::KIND_STOP, 8'hFF, 1'b1, 1'b1);
        drive_until_idle(SDA_RANDOM);
        send_item(i2cm_pkg::KIND_WRITE, 8'h00, 1'b0, 1'b0);
        drive_until_idle(SDA_RANDOM);
        send_item(i2cm_pkg::KIND_WRITE, 8'hFF, 1'b1, 1'b1);
        drive_until_idle(SDA_RANDOM);
        send_item(i2cm_pkg::KIND_READ, 8'h80, 1'b0, 1'b0);
        drive_until_idle(SDA_HIGH);
        send_item(i2cm_pkg::KIND_READ, 8'h01, 1'b1, 1'b1);
        drive_until_idle(SDA_LOW);
        send_item(i2cm_pkg::KIND_ACK, 8'h00, 1'b0, 1'b0);
        drive_until_idle(SDA_RANDOM);
        send_item(i2cm_pkg::KIND_ACK, 8'h00, 1'b1, 1'b0);
        drive_until_idle(SDA_RANDOM);
        send_item(i2cm_pkg::KIND_WAIT, 8'h00, 1'b0, 1'b1);
        drive_until_idle(SDA_LOW);
        send_item(i2cm_pkg::KIND_WAIT, 8'h00, 1'b0, 1'b0);
        drive_until_idle(SDA_HIGH);
        send_item(i2cm_pkg::KIND_STOP, 8'h00, 1'b0, 1'b0);
        drive_until_idle(SDA_RANDOM);

        configure(16'hFFFF, 8'hFF);
        send_item(i2cm_pkg::KIND_WAIT, 8'h00, 1'b0, 1'b1);
        drive_until_idle(SDA_LOW);

        configure(16'd1, 8'd3);
        rx_hold_left = 40;
        run_random(100);

        configure(16'd0, 8'd0);
        tx_idle_pct = 60;
        run_random(100);

        configure(16'($urandom_range(2, 4)), 8'd255);
        tx_idle_pct  = 0;
        rx_stall_pct = 60;
        run_random(100);

        configure(16'd2, 8'($urandom_range(4, 12)));
        tx_idle_pct  = 35;
        rx_stall_pct = 35;
        run_random(100);

        settle();
        repeat (4) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
